FILE: sv/sros_pkg.sv
// Shared types and constants for the sorted range owner search block.
package sros_pkg;

  localparam int DEF_TABLE_DEPTH = 256;

  localparam int RANK_W  = 24;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 8;
  localparam int CFG_W   = 9;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  typedef struct packed {
    logic [RANK_W-1:0]  start;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] owner;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_RESULT
  } state_e;

endpackage

FILE: sv/sorted_range_owner_search.sv
// Top level of the sorted range owner search block.
//
// Requests enter on the in_* channel (valid/stall). A write request
// (func 0) stores start and count at entry_index and gives no
// result. A lookup request (func 1) runs a binary search over the first
// entries_in_use entries and gives one result on the out_* channel.
// Each halving step of a lookup takes one table read and one compare, both
// on the single read port of the table memory, and a final step loads the
// result register. One request is in progress at a time; in_stall_o
// is high from the cycle after a lookup is taken until its result is handed
// to the output register, so a new lookup is taken only after the last one's
// result is handed on, and writes are taken once a cycle while no lookup is
// in progress. The output register lets the next request in while a result
// waits; when out_stall_i holds the result, a later lookup waits in its final
// step. entries_in_use is written through the cfg_* channel, always ready.
// Reset clears the sequencer, the output valid flag and entries_in_use; the
// table holds no reset value and needs no clearing.
module sorted_range_owner_search import sros_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_func_i,
  input  logic [INDEX_W-1:0] in_entry_index_i,
  input  logic [RANK_W-1:0]  in_entry_start_i,
  input  logic [COUNT_W-1:0] in_entry_count_i,
  input  logic [RANK_W-1:0]  in_query_rank_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               out_found_o,
  output logic [INDEX_W-1:0] out_owner_index_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_W-1:0]   cfg_entries_in_use_i
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CFG_W-1:0] cfg_q;
  logic             out_valid_q;
  res_t             out_q;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cfg_q <= cfg_entries_in_use_i;
    end
  end

  sros_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i,
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  sros_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_search (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_func_i,
    .in_entry_index_i,
    .in_entry_start_i,
    .in_entry_count_i,
    .in_query_rank_i,
    .cfg_q_i     (cfg_q),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_found_o       = out_q.found;
  assign out_owner_index_o = out_q.owner;

  a_miss_owner_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_found_o |-> out_owner_index_o == '0)
    else $error("miss result carries a nonzero owner index");

  a_owner_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_found_o |-> CFG_W'(out_owner_index_o) < cfg_q)
    else $error("owner index outside the entries in use");

  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_func_i == FUNC_LOOKUP |=> in_stall_o)
    else $error("lookup did not hold off the next request");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_func_i == FUNC_WRITE |=> !$rose(out_valid_o))
    else $error("write request produced a result");

endmodule

FILE: sv/sros_table.sv
// Range table memory: one write port, one registered read port.
module sros_table import sros_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/sros_search.sv
// Request intake and binary search sequencer over the range table.
module sros_search import sros_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                in_func_i,
  input  logic [INDEX_W-1:0]  in_entry_index_i,
  input  logic [RANK_W-1:0]   in_entry_start_i,
  input  logic [COUNT_W-1:0]  in_entry_count_i,
  input  logic [RANK_W-1:0]   in_query_rank_i,
  input  logic [CFG_W-1:0]    cfg_q_i,
  output logic                wr_en_o,
  output logic [IDX_W-1:0]    wr_addr_o,
  output entry_t              wr_data_o,
  output logic                rd_en_o,
  output logic [IDX_W-1:0]    rd_addr_o,
  input  entry_t              rd_data_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]  low_q, low_d;
  logic [CNT_W-1:0]  hi_q, hi_d;
  logic [IDX_W-1:0]  mid_q, mid_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              found_q, found_d;

  logic              accept;
  logic              active;
  logic [CNT_W-1:0]  n_use;
  logic [CNT_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid_calc;
  logic [RANK_W:0]   end_rank;
  logic              go_left;
  logic              go_right;

  assign accept = in_valid_i && !in_stall_o;
  assign active = low_q < hi_q;

  always_comb begin
    if (32'(cfg_q_i) > 32'(TABLE_DEPTH)) begin
      n_use = CNT_W'(TABLE_DEPTH);
    end else begin
      n_use = CNT_W'(cfg_q_i);
    end
  end

  assign mid_sum  = (CNT_W+1)'(low_q) + (CNT_W+1)'(hi_q) - (CNT_W+1)'(1);
  assign mid_calc = IDX_W'(mid_sum >> 1);

  assign end_rank = {1'b0, rd_data_i.start} + (RANK_W+1)'(rd_data_i.count);
  assign go_left  = rank_q < rd_data_i.start;
  assign go_right = !go_left && ((RANK_W+1)'(rank_q) >= end_rank);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_func_i == FUNC_LOOKUP)) begin
          state_d = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (active) begin
          state_d = ST_COMPARE;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_COMPARE: begin
        if (go_left || go_right) begin
          state_d = ST_PROBE;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    wr_en_o     = 1'b0;
    wr_addr_o   = IDX_W'(in_entry_index_i);
    wr_data_o   = '{start: in_entry_start_i, count: in_entry_count_i};
    rd_en_o     = 1'b0;
    rd_addr_o   = mid_calc;
    res_valid_o = 1'b0;
    res_o       = '{found: found_q, owner: found_q ? INDEX_W'(mid_q) : '0};
    low_d       = low_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    rank_d      = rank_q;
    found_d     = found_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_func_i == FUNC_WRITE)) begin
          wr_en_o = 32'(in_entry_index_i) < 32'(TABLE_DEPTH);
        end
        if (accept && (in_func_i == FUNC_LOOKUP)) begin
          low_d   = '0;
          hi_d    = n_use;
          rank_d  = in_query_rank_i;
          found_d = 1'b0;
        end
      end
      ST_PROBE: begin
        if (active) begin
          rd_en_o = 1'b1;
          mid_d   = mid_calc;
        end
      end
      ST_COMPARE: begin
        if (go_left) begin
          hi_d = CNT_W'(mid_q);
        end else if (go_right) begin
          low_d = CNT_W'(mid_q) + CNT_W'(1);
        end else begin
          found_d = 1'b1;
        end
      end
      ST_RESULT: begin
        res_valid_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q   <= low_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    rank_q  <= rank_d;
    found_q <= found_d;
  end

endmodule
